@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the digit converter RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/r2a_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2a_pkg
// Types, constants and the digit encoder of the radix to ASCII converter.
// ----------------------------------------------------------------------------
package r2a_pkg;

  localparam int RADIX_W       = 8;
  localparam int BASE_W        = 5;
  localparam int DIGIT_W       = 4;
  localparam int CHAR_W        = 8;
  localparam int DIV_STEP      = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [RADIX_W-1:0] BASE_MIN      = 8'd2;
  localparam logic [RADIX_W-1:0] BASE_MAX      = 8'd16;
  localparam logic [BASE_W-1:0]  BASE_FALLBACK = 5'd10;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0]  ASCII_ALPHA   = 8'h41;
  localparam logic [DIGIT_W-1:0] FIRST_LETTER  = 4'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } st_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] wide;
    wide = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d >= FIRST_LETTER) begin
      return ASCII_ALPHA + wide - {{(CHAR_W-DIGIT_W){1'b0}}, FIRST_LETTER};
    end
    return ASCII_ZERO + wide;
  endfunction

endpackage

@@ hdl/r2a_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2a_if
// Valid/ready channels of the converter: number in, characters out.
// ----------------------------------------------------------------------------
interface r2a_in_if #(
  parameter int VALUE_BITS = 31
);
  logic                             valid;
  logic                             ready;
  logic [VALUE_BITS-1:0]            value;
  logic [r2a_pkg::RADIX_W-1:0]      base;

  modport source (output valid, output value, output base, input ready);
  modport sink   (input valid, input value, input base, output ready);
endinterface

interface r2a_out_if;
  logic                             valid;
  logic                             ready;
  logic [r2a_pkg::CHAR_W-1:0]       ascii_char;
  logic                             last;

  modport source (output valid, output ascii_char, output last, input ready);
  modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

@@ hdl/r2a_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2a_front
// Accepts a number and maps its radix onto 2..16, falling back to ten.
// ----------------------------------------------------------------------------
module r2a_front #(
  parameter int VALUE_BITS = 31
) (
  r2a_in_if.sink                      din,
  output r2a_pkg::hs_t                job_hs_out,
  input  logic                        job_ready,
  output logic [VALUE_BITS-1:0]       job_value,
  output logic [r2a_pkg::BASE_W-1:0]  job_base
);

  always_comb begin
    job_value = din.value;
    if (din.base inside {[r2a_pkg::BASE_MIN:r2a_pkg::BASE_MAX]}) begin
      job_base = din.base[r2a_pkg::BASE_W-1:0];
    end else begin
      job_base = r2a_pkg::BASE_FALLBACK;
    end
  end

  assign job_hs_out.valid = din.valid;
  assign job_hs_out.ready = job_ready;
  assign din.ready        = job_ready;

endmodule

@@ hdl/r2a_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2a_queue
// Short FIFO of classified numbers between the front and the divider.
// ----------------------------------------------------------------------------
module r2a_queue #(
  parameter int VALUE_BITS = 31
) (
  input  logic                        clk,
  input  logic                        rst,
  input  r2a_pkg::hs_t                wr_hs,
  output logic                        wr_ready,
  input  logic [VALUE_BITS-1:0]       wr_value,
  input  logic [r2a_pkg::BASE_W-1:0]  wr_base,
  output logic                        rd_valid,
  input  logic                        rd_ready,
  output logic [VALUE_BITS-1:0]       rd_value,
  output logic [r2a_pkg::BASE_W-1:0]  rd_base
);

  localparam int DEPTH = r2a_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [VALUE_BITS-1:0]       q_value [DEPTH];
  logic [r2a_pkg::BASE_W-1:0]  q_base  [DEPTH];
  logic [PTR_W-1:0]            wr_ptr;
  logic [PTR_W-1:0]            rd_ptr;
  logic [CNT_W-1:0]            cnt;
  logic                        do_wr;
  logic                        do_rd;

  assign wr_ready = (cnt != CNT_W'(DEPTH));
  assign rd_valid = (cnt != '0);
  assign do_wr    = wr_hs.valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_value = q_value[rd_ptr];
  assign rd_base  = q_base[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_value[wr_ptr] <= wr_value;
      q_base[wr_ptr]  <= wr_base;
    end
  end

endmodule

@@ hdl/r2a_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2a_back
// Repeated division onto a digit stack, then popping to ASCII characters.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module r2a_back #(
  parameter int VALUE_BITS = 31,
  parameter int MAX_DIGITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        job_valid,
  output logic                        job_ready,
  input  logic [VALUE_BITS-1:0]       job_value,
  input  logic [r2a_pkg::BASE_W-1:0]  job_base,
  r2a_out_if.source                   dout
);

  localparam int STEP   = r2a_pkg::DIV_STEP;
  localparam int ROUNDS = (VALUE_BITS + STEP - 1) / STEP;
  localparam int DIV_W  = ROUNDS * STEP;
  localparam int RND_W  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int SP_W   = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W  = $clog2(MAX_DIGITS);
  localparam int DW     = r2a_pkg::DIGIT_W;
  localparam int BW     = r2a_pkg::BASE_W;

  r2a_pkg::st_t       state;
  r2a_pkg::st_t       state_next;

  logic [DIV_W-1:0]   dvd;
  logic [DW-1:0]      rem;
  logic [BW-1:0]      base_r;
  logic [RND_W-1:0]   rnd;
  logic [SP_W-1:0]    sp;
  logic [SP_W-1:0]    sp_m1;
  logic               rd_pend;
  logic               rd_last;
  logic [DW-1:0]      mem [MAX_DIGITS];
  logic [DW-1:0]      mem_q;
  logic               out_valid;
  logic [r2a_pkg::CHAR_W-1:0] out_char;
  logic               out_last;

  logic [STEP-1:0]    q_bits;
  logic [DW-1:0]      rem_next;
  logic [DIV_W-1:0]   quo;
  logic               last_round;
  logic               div_done;
  logic               push;
  logic               rd_issue;
  logic               load;
  logic               take_job;

  always_comb begin
    logic [BW-1:0] t;
    logic [DW-1:0] r;
    r      = rem;
    q_bits = '0;
    for (int i = 0; i < STEP; i++) begin
      t = {r, dvd[DIV_W-1-i]};
      if (t >= base_r) begin
        t = t - base_r;
        q_bits[STEP-1-i] = 1'b1;
      end
      r = t[DW-1:0];
    end
    rem_next = r;
    quo      = (dvd << STEP) | DIV_W'(q_bits);
  end

  assign last_round = (rnd == '0);
  assign div_done   = last_round && (quo == '0);
  assign sp_m1      = sp - 1'b1;
  assign push       = (state == r2a_pkg::ST_DIV) && last_round && (sp < SP_W'(MAX_DIGITS));
  assign load       = rd_pend && (!out_valid || dout.ready);
  assign rd_issue   = (state == r2a_pkg::ST_EMIT) && (sp != '0) && (!rd_pend || load);
  assign take_job   = job_valid && job_ready;

  always_comb begin
    state_next = state;
    job_ready  = 1'b0;
    case (state)
      r2a_pkg::ST_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          state_next = r2a_pkg::ST_DIV;
        end
      end
      r2a_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = r2a_pkg::ST_EMIT;
        end
      end
      r2a_pkg::ST_EMIT: begin
        if ((sp == '0) && !rd_pend) begin
          state_next = r2a_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = r2a_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= r2a_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd       <= '0;
      sp        <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take_job) begin
        rnd <= RND_W'(ROUNDS - 1);
        sp  <= '0;
      end else if (state == r2a_pkg::ST_DIV) begin
        rnd <= last_round ? RND_W'(ROUNDS - 1) : rnd - 1'b1;
        if (push) begin
          sp <= sp + 1'b1;
        end
      end else if (rd_issue) begin
        sp <= sp_m1;
      end
      if (rd_issue) begin
        rd_pend <= 1'b1;
      end else if (load) begin
        rd_pend <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_job) begin
      dvd    <= DIV_W'(job_value);
      rem    <= '0;
      base_r <= job_base;
    end else if (state == r2a_pkg::ST_DIV) begin
      if (last_round) begin
        dvd <= quo;
        rem <= '0;
      end else begin
        dvd <= quo;
        rem <= rem_next;
      end
    end
    if (rd_issue) begin
      rd_last <= (sp == SP_W'(1));
    end
    if (load) begin
      out_char <= r2a_pkg::digit_to_ascii(mem_q);
      out_last <= rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[sp[IDX_W-1:0]] <= rem_next;
    end
    if (rd_issue) begin
      mem_q <= mem[sp_m1[IDX_W-1:0]];
    end
  end

  assign dout.valid      = out_valid;
  assign dout.ascii_char = out_char;
  assign dout.last       = out_last;

  `ASSERT_RST(a_pend_in_emit, clk, rst, rd_pend |-> (state == r2a_pkg::ST_EMIT), "read pending outside emit")
  `ASSERT_RST(a_sp_bound, clk, rst, sp <= SP_W'(MAX_DIGITS), "digit stack overflow")
  `ASSERT_RST(a_base_range, clk, rst, (state == r2a_pkg::ST_DIV) |-> ((base_r >= BW'(2)) && (base_r <= BW'(16))), "radix out of range in divider")
  `ASSERT_RST(a_rem_below_base, clk, rst, (state == r2a_pkg::ST_DIV) |-> (rem < base_r), "partial remainder not below radix")

endmodule

@@ hdl/radix_to_ascii_digits_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_to_ascii_digits_unit
// Converts a number to ASCII digits in radix 2..16, most significant first.
// ----------------------------------------------------------------------------
//  channel | dir | payload           | transaction
//  din     | in  | value, base       | one number to convert
//  dout    | out | ascii_char, last  | one character, last on the final one
//
//  The shared divider retires 8 quotient bits per cycle.
//  Characters then leave the digit stack at one per cycle while dout is ready.
//  A two-entry queue lets din keep taking numbers while the divider works.
//  Reset is synchronous and clears control state only; no clearing pass.
//  A stalled dout holds its character and pauses popping.
// ----------------------------------------------------------------------------
module radix_to_ascii_digits_unit #(
  parameter int VALUE_BITS = 31,
  parameter int MAX_DIGITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  r2a_in_if.sink      din,
  r2a_out_if.source   dout
);

  r2a_pkg::hs_t                front_hs;
  logic                        front_ready;
  logic [VALUE_BITS-1:0]       front_value;
  logic [r2a_pkg::BASE_W-1:0]  front_base;
  logic                        job_valid;
  logic                        job_ready;
  logic [VALUE_BITS-1:0]       job_value;
  logic [r2a_pkg::BASE_W-1:0]  job_base;

  r2a_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .din        (din),
    .job_hs_out (front_hs),
    .job_ready  (front_ready),
    .job_value  (front_value),
    .job_base   (front_base)
  );

  r2a_queue #(
    .VALUE_BITS (VALUE_BITS)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_hs    (front_hs),
    .wr_ready (front_ready),
    .wr_value (front_value),
    .wr_base  (front_base),
    .rd_valid (job_valid),
    .rd_ready (job_ready),
    .rd_value (job_value),
    .rd_base  (job_base)
  );

  r2a_back #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_value (job_value),
    .job_base  (job_base),
    .dout      (dout)
  );

endmodule

@@ dv/radix_to_ascii_digits_unit_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_to_ascii_digits_unit_checker
// Watches the number and character channels of the converter. Every accepted
// number is expanded into its expected digit string, and every accepted
// character is compared with the oldest character still due.
// ----------------------------------------------------------------------------
module radix_to_ascii_digits_unit_checker #(
  parameter int VALUE_BITS = 31,
  parameter int MAX_DIGITS = 32
) (
  input  logic clk,
  input  logic rst,
  r2a_in_if    din,
  r2a_out_if   dout,
  output int   failures,
  output int   chars_pending,
  output int   numbers_seen,
  output int   chars_seen
);

  localparam int CHAR_W  = r2a_pkg::CHAR_W;
  localparam int DIGIT_W = r2a_pkg::DIGIT_W;
  localparam int RADIX_W = r2a_pkg::RADIX_W;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_char_t;

  digit_char_t chars_due[$];

  function automatic void expand_digits(input logic [VALUE_BITS-1:0] value,
                                        input logic [RADIX_W-1:0]    base);
    logic [VALUE_BITS-1:0] rest;
    int unsigned           radix;
    logic [DIGIT_W-1:0]    stack [MAX_DIGITS];
    int                    depth;
    digit_char_t           entry;
    rest  = value;
    radix = 32'(base);
    if (base < r2a_pkg::BASE_MIN || base > r2a_pkg::BASE_MAX) begin
      radix = 32'(r2a_pkg::BASE_FALLBACK);
    end
    depth = 0;
    while (32'(rest) >= radix) begin
      if (depth < MAX_DIGITS) begin
        stack[depth] = DIGIT_W'(32'(rest) % radix);
        depth++;
      end
      rest = VALUE_BITS'(32'(rest) / radix);
    end
    if (depth < MAX_DIGITS) begin
      stack[depth] = DIGIT_W'(rest);
      depth++;
    end
    for (int k = depth - 1; k >= 0; k--) begin
      if (stack[k] >= r2a_pkg::FIRST_LETTER) begin
        entry.ch = r2a_pkg::ASCII_ALPHA + CHAR_W'(stack[k])
                   - CHAR_W'(r2a_pkg::FIRST_LETTER);
      end else begin
        entry.ch = r2a_pkg::ASCII_ZERO + CHAR_W'(stack[k]);
      end
      entry.last = (k == 0);
      chars_due.push_back(entry);
    end
  endfunction

  always @(posedge clk) begin
    digit_char_t want;
    if (rst) begin
      failures     = 0;
      numbers_seen = 0;
      chars_seen   = 0;
      chars_due.delete();
    end else begin
      if (din.valid && din.ready) begin
        expand_digits(din.value, din.base);
        numbers_seen++;
      end
      if (dout.valid && dout.ready) begin
        chars_seen++;
        if (chars_due.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("%0t: unexpected character 0x%02h last=%0b", $realtime,
                     dout.ascii_char, dout.last);
          end
        end else begin
          want = chars_due.pop_front();
          if (dout.ascii_char !== want.ch || dout.last !== want.last) begin
            failures++;
            if (failures <= 10) begin
              $display("%0t: mismatch: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                       $realtime, want.ch, want.last, dout.ascii_char, dout.last);
            end
          end
        end
      end
    end
    chars_pending = chars_due.size();
  end

endmodule

@@ dv/radix_to_ascii_digits_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_to_ascii_digits_unit_tb
// Drives numbers and bases into the converter with random gaps and random
// backpressure on the characters; a checker beside the block predicts and
// compares every character.
// ----------------------------------------------------------------------------
module radix_to_ascii_digits_unit_tb;

  localparam int VALUE_BITS   = 31;
  localparam int MAX_DIGITS   = 32;
  localparam int RADIX_W      = r2a_pkg::RADIX_W;
  localparam int RANDOM_ITEMS = 396;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 200;

  logic clk;
  logic rst;
  int   failures;
  int   chars_pending;
  int   numbers_seen;
  int   chars_seen;
  int   cycles;
  int   numbers_sent;
  int   fallback_sent;

  r2a_in_if #(.VALUE_BITS(VALUE_BITS)) din_ch ();
  r2a_out_if                            dout_ch ();

  radix_to_ascii_digits_unit #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .din (din_ch),
    .dout(dout_ch)
  );

  radix_to_ascii_digits_unit_checker #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .din          (din_ch),
    .dout         (dout_ch),
    .failures     (failures),
    .chars_pending(chars_pending),
    .numbers_seen (numbers_seen),
    .chars_seen   (chars_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("[radix_to_ascii_digits_unit] ERROR");
    $finish;
  end

  // backpressure on characters, with calm stretches of constant ready
  initial begin
    int stall;
    int grants;
    grants = 0;
    dout_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = (grants % 50 < 12) ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        dout_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      dout_ch.ready <= 1'b1;
      @(posedge clk);
      while (!dout_ch.valid) @(posedge clk);
      grants++;
    end
  end

  task automatic send_number(input logic [VALUE_BITS-1:0] value,
                             input logic [RADIX_W-1:0]    base);
    int gap;
    gap = (numbers_sent % 64 < 16) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      din_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_ch.valid <= 1'b1;
    din_ch.value <= value;
    din_ch.base  <= base;
    @(posedge clk);
    while (!din_ch.ready) @(posedge clk);
    numbers_sent++;
    if (base < r2a_pkg::BASE_MIN || base > r2a_pkg::BASE_MAX) begin
      fallback_sent++;
    end
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value();
    logic [VALUE_BITS-1:0] full;
    int                    shift;
    full  = VALUE_BITS'($urandom);
    shift = $urandom_range(0, VALUE_BITS - 1);
    case ($urandom_range(0, 3))
      0:       return full;
      1:       return full >> shift;
      2:       return VALUE_BITS'($urandom_range(0, 40));
      default: begin
        if ($urandom_range(0, 1) != 0) begin
          return VALUE_BITS'(1) << shift;
        end
        return (VALUE_BITS'(1) << shift) - VALUE_BITS'(1);
      end
    endcase
  endfunction

  function automatic logic [RADIX_W-1:0] pick_base();
    if ($urandom_range(0, 9) == 0) begin
      return RADIX_W'($urandom_range(0, 255));
    end
    return RADIX_W'($urandom_range(r2a_pkg::BASE_MIN, r2a_pkg::BASE_MAX));
  endfunction

  initial begin
    logic [VALUE_BITS-1:0] all_ones;
    all_ones      = '1;
    numbers_sent  = 0;
    fallback_sent = 0;
    rst          <= 1'b1;
    din_ch.valid <= 1'b0;
    din_ch.value <= '0;
    din_ch.base  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_number('0, 8'd10);
    send_number('0, 8'd2);
    send_number('0, 8'd255);
    send_number(all_ones, 8'd2);
    send_number(all_ones, 8'd16);
    send_number(all_ones, 8'd10);
    send_number(all_ones, 8'd3);
    send_number(all_ones, 8'd0);
    send_number(all_ones, 8'd1);
    send_number(all_ones, 8'd17);
    send_number(all_ones, 8'd255);
    send_number(31'h2AAAAAAA, 8'd16);
    send_number(31'h55555555, 8'd7);
    send_number(31'd1, 8'd16);
    send_number(31'd15, 8'd16);
    send_number(31'd16, 8'd16);
    send_number(31'd9, 8'd10);
    send_number(31'd10, 8'd11);
    send_number(31'd255, 8'd16);
    send_number(31'd1234567, 8'd12);
    send_number(31'd99999, 8'd13);
    send_number(31'd65535, 8'd8);
    send_number(31'd1000, 8'd128);
    send_number(31'd4242, 8'd15);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      send_number(pick_value(), pick_base());
    end
    din_ch.valid <= 1'b0;

    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d numbers (%0d with an out-of-range base) into %0d characters",
             numbers_seen, fallback_sent, chars_seen);
    $display("failures: %0d, characters still due: %0d", failures, chars_pending);
    if (failures == 0 && chars_pending == 0) begin
      $display("[radix_to_ascii_digits_unit] OK");
    end else begin
      $display("[radix_to_ascii_digits_unit] ERROR");
    end
    $finish;
  end

endmodule
